// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Command and status codes, widths, and the controller/datapath link types.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QueueDepth = 64;
	localparam int IdxW       = $clog2(QueueDepth);
	localparam int CntW       = IdxW + 1;
	localparam int KeyW       = 16;
	localparam int HndW       = 16;

	localparam logic [2:0] CMD_OFFER   = 3'd0;
	localparam logic [2:0] CMD_POLL    = 3'd1;
	localparam logic [2:0] CMD_READ    = 3'd2;
	localparam logic [2:0] CMD_RM_HND  = 3'd3;
	localparam logic [2:0] CMD_RM_IDX  = 3'd4;
	localparam logic [2:0] CMD_CLEAR   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISSING  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch the incoming command
		logic exec;   // run a command other than remove handle and capture its result
		logic scan;   // one remove-handle step
	} spq_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_rm_hnd;  // latched command is remove handle
		logic match_any;  // some held entry still carries the handle
	} spq_sts_t;

endpackage

// File: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Offer, poll, read, remove at index, clear: the command is latched in S_IDLE, runs in S_EXEC, then the result strobes.
// Remove handle: S_SCAN steps until no entry carries the handle (one cell delete per cycle).
// A new command is taken only in S_IDLE, once the previous one is through; busy is high meanwhile.
// Reset: arst_n clears occupancy and controller; the receiver cannot stall results.
// ----------------------------------------------------------------------------
// sorted_priority_queue: key-ordered queue of (key, handle) entries
// Controller plus shifting cell-array datapath.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [2:0]      cmd,
	input  logic [KeyW-1:0] key,
	input  logic [HndW-1:0] handle,
	input  logic [IdxW-1:0] index,
	output logic            done,
	output logic [1:0]      status,
	output logic [IdxW-1:0] position,
	output logic [HndW-1:0] out_handle,
	output logic [KeyW-1:0] out_key,
	output logic [CntW-1:0] removed_count,
	output logic [CntW-1:0] occupancy
);

	spq_ctl_t ctl;
	spq_sts_t sts;

	// sequencer
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	// cell array
	spq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.key           (key),
		.handle        (handle),
		.index         (index),
		.status        (status),
		.position      (position),
		.out_handle    (out_handle),
		.out_key       (out_key),
		.removed_count (removed_count),
		.occupancy     (occupancy)
	);

endmodule

// File: hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: command sequencer
// Accepts a command, runs it in S_EXEC or, for remove handle, steps
// the datapath, deleting one matching entry per step until none is left, then strobes the result.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output spq_ctl_t ctl,
	input  spq_sts_t sts
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.is_rm_hnd) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (!sts.match_any) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		ctl.load = (state_q == S_IDLE) && start;
		ctl.exec = (state_q == S_EXEC) && !sts.is_rm_hnd;
		ctl.scan = (state_q == S_SCAN);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != S_IDLE)
		else $error("result strobe without work");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");
	a_scan_only_rm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> sts.is_rm_hnd)
		else $error("scan state for a command other than remove handle");

endmodule

// File: hw/rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted cell array and result registers
// Cells hold key/handle in ascending key order; insert and delete shift
// the array by one place.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_ctl_t        ctl,
	output spq_sts_t        sts,
	input  logic [2:0]      cmd,
	input  logic [KeyW-1:0] key,
	input  logic [HndW-1:0] handle,
	input  logic [IdxW-1:0] index,
	output logic [1:0]      status,
	output logic [IdxW-1:0] position,
	output logic [HndW-1:0] out_handle,
	output logic [KeyW-1:0] out_key,
	output logic [CntW-1:0] removed_count,
	output logic [CntW-1:0] occupancy
);

	logic [KeyW-1:0] cell_key_q [QueueDepth];
	logic [HndW-1:0] cell_hnd_q [QueueDepth];
	logic [CntW-1:0] total_q;
	logic [CntW-1:0] rm_cnt_q;

	logic [2:0]      cmd_q;
	logic [KeyW-1:0] key_q;
	logic [HndW-1:0] hnd_q;
	logic [IdxW-1:0] idx_q;

	logic [1:0]      res_status_q;
	logic [IdxW-1:0] res_pos_q;
	logic [HndW-1:0] res_hnd_q;
	logic [KeyW-1:0] res_key_q;
	logic [CntW-1:0] res_rm_q;
	logic [CntW-1:0] res_occ_q;

	logic [QueueDepth-1:0] valid, le, match;
	logic [IdxW-1:0] ins_pos, match_pos, eff_idx, drop_at;
	logic            full, present, is_idx_cmd;
	logic            ins_en, drop_en;
	logic [CntW-1:0] total_nxt;

	// per-cell compares
	always_comb begin
		for (int i = 0; i < QueueDepth; i++) begin
			valid[i] = CntW'(i) < total_q;
			le[i]    = valid[i] && (cell_key_q[i] <= key_q);
			match[i] = valid[i] && (cell_hnd_q[i] == hnd_q);
		end
	end

	// first cell past the key, first cell with the handle
	always_comb begin
		ins_pos   = '0;
		match_pos = '0;
		for (int i = QueueDepth - 1; i >= 0; i--) begin
			if (!le[i])   ins_pos   = IdxW'(i);
			if (match[i]) match_pos = IdxW'(i);
		end
	end

	assign full       = total_q >= CntW'(QueueDepth);
	assign eff_idx    = (cmd_q == CMD_POLL) ? '0 : idx_q;
	assign present    = {1'b0, eff_idx} < total_q;
	assign is_idx_cmd = (cmd_q == CMD_POLL) || (cmd_q == CMD_READ) || (cmd_q == CMD_RM_IDX);

	assign sts.is_rm_hnd = (cmd_q == CMD_RM_HND);
	assign sts.match_any = |match;

	// array operation select
	always_comb begin
		ins_en  = ctl.exec && (cmd_q == CMD_OFFER) && !full;
		drop_en = (ctl.exec && present && ((cmd_q == CMD_POLL) || (cmd_q == CMD_RM_IDX)))
			|| (ctl.scan && sts.match_any);
		drop_at = ctl.scan ? match_pos : eff_idx;
		total_nxt = total_q;
		if (ctl.exec && (cmd_q == CMD_CLEAR)) total_nxt = '0;
		else if (ins_en)                     total_nxt = total_q + CntW'(1);
		else if (drop_en)                    total_nxt = total_q - CntW'(1);
	end

	// cell array shifts
	always_ff @(posedge clk) begin
		for (int i = 0; i < QueueDepth; i++) begin
			if (ins_en) begin
				if (IdxW'(i) == ins_pos) begin
					cell_key_q[i] <= key_q;
					cell_hnd_q[i] <= hnd_q;
				end else if (i > 0 && IdxW'(i) > ins_pos) begin
					cell_key_q[i] <= cell_key_q[(i > 0) ? i - 1 : 0];
					cell_hnd_q[i] <= cell_hnd_q[(i > 0) ? i - 1 : 0];
				end
			end else if (drop_en) begin
				if (i < QueueDepth - 1 && IdxW'(i) >= drop_at) begin
					cell_key_q[i] <= cell_key_q[(i < QueueDepth - 1) ? i + 1 : i];
					cell_hnd_q[i] <= cell_hnd_q[(i < QueueDepth - 1) ? i + 1 : i];
				end
			end
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			key_q <= key;
			hnd_q <= handle;
			idx_q <= index;
		end
	end

	// occupancy and remove counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			rm_cnt_q <= '0;
		end else begin
			total_q <= total_nxt;
			if (ctl.load)                         rm_cnt_q <= '0;
			else if (ctl.scan && sts.match_any)   rm_cnt_q <= rm_cnt_q + CntW'(1);
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (ctl.exec || (ctl.scan && !sts.match_any)) begin
			res_status_q <= ST_OK;
			res_pos_q    <= '0;
			res_hnd_q    <= '0;
			res_key_q    <= '0;
			res_rm_q     <= ctl.scan ? rm_cnt_q : '0;
			res_occ_q    <= total_nxt;
			if (ctl.exec && cmd_q == CMD_OFFER) begin
				if (full) res_status_q <= ST_FULL;
				else      res_pos_q    <= ins_pos;
			end else if (ctl.exec && is_idx_cmd) begin
				if (!present) begin
					res_status_q <= ST_MISSING;
				end else begin
					res_hnd_q <= cell_hnd_q[eff_idx];
					res_key_q <= cell_key_q[eff_idx];
				end
			end
		end
	end

	assign status        = res_status_q;
	assign position      = res_pos_q;
	assign out_handle    = res_hnd_q;
	assign out_key       = res_key_q;
	assign removed_count = res_rm_q;
	assign occupancy     = res_occ_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CntW'(QueueDepth))
		else $error("occupancy above depth");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins_en && drop_en))
		else $error("insert and delete in one cycle");

endmodule
